// ===== hw/rtl/bsd_pkg.sv =====
// Package for the block stream deframer: codes, widths and shared types.
`timescale 1ns / 1ps
package bsd_pkg;

  localparam int LENGTH_BITS       = 24;
  localparam int DIGEST_HEX_DIGITS = 40;
  localparam int DC_W              = $clog2(DIGEST_HEX_DIGITS + 1);
  localparam int CONTENT_LEN_W     = 24;

  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_V    = 8'h56;
  localparam logic [7:0] CH_LF   = 8'h0A;

  localparam logic [LENGTH_BITS-1:0] TRAILER_MARKS = LENGTH_BITS'(2);

  localparam logic [2:0] KIND_SKIP    = 3'd0;
  localparam logic [2:0] KIND_TYPE    = 3'd1;
  localparam logic [2:0] KIND_HEADER  = 3'd2;
  localparam logic [2:0] KIND_CONTENT = 3'd3;
  localparam logic [2:0] KIND_DIGIT   = 3'd4;
  localparam logic [2:0] KIND_DONE    = 3'd5;
  localparam logic [2:0] KIND_ERROR   = 3'd6;

  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_UNEXP_TRAIL = 3'd1;
  localparam logic [2:0] ERR_FORMAT      = 3'd2;
  localparam logic [2:0] ERR_VERSION     = 3'd3;
  localparam logic [2:0] ERR_HDR_LF      = 3'd4;
  localparam logic [2:0] ERR_NO_TRAILER  = 3'd5;
  localparam logic [2:0] ERR_TRAIL_LF    = 3'd6;
  localparam logic [2:0] ERR_OVERFLOW    = 3'd7;

  localparam logic REG_CHECKSUM_MODE    = 1'b0;
  localparam logic REG_EXPECTED_VERSION = 1'b1;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_IF_DIGITS = 2'd1;

  typedef enum logic [3:0] {
    PH_SEARCH    = 4'd0,
    PH_TYPE      = 4'd1,
    PH_VERSION   = 4'd2,
    PH_HDRLEN    = 4'd3,
    PH_HEADER    = 4'd4,
    PH_DATALEN   = 4'd5,
    PH_HDREND    = 4'd6,
    PH_CONTENT   = 4'd7,
    PH_TRAILER   = 4'd8,
    PH_CHECKSUM  = 4'd9,
    PH_CHECKDATA = 4'd10,
    PH_BLOCKEND  = 4'd11
  } phase_t;

  typedef struct packed {
    logic [1:0] checksum_mode;
    logic [7:0] expected_version;
  } cfg_t;

  typedef struct packed {
    logic [2:0]               byte_kind;
    logic [7:0]               byte_value;
    logic                     hash_feed;
    logic [2:0]               error_code;
    logic [15:0]              block_index;
    logic [7:0]               block_kind;
    logic [CONTENT_LEN_W-1:0] content_length;
    logic                     need_verify;
  } res_t;

endpackage

// ===== hw/rtl/bsd_cfg_regs.sv =====
// APB register file holding checksum mode and expected version.
`timescale 1ns / 1ps
module bsd_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output bsd_pkg::cfg_t cfg
);
  import bsd_pkg::*;

  logic [1:0] mode_r;
  logic [7:0] version_r;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IF_DIGITS;
      version_r <= 8'd1;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_CHECKSUM_MODE:    mode_r    <= pwdata[1:0];
        REG_EXPECTED_VERSION: version_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_CHECKSUM_MODE:    prdata = {30'd0, mode_r};
      REG_EXPECTED_VERSION: prdata = {24'd0, version_r};
      default:              prdata = 32'd0;
    endcase
  end

  assign cfg.checksum_mode    = mode_r;
  assign cfg.expected_version = version_r;

endmodule

// ===== hw/rtl/bsd_parser.sv =====
// Deframer state registers and the per-byte decode logic.
`timescale 1ns / 1ps
module bsd_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_en,
  input  logic [7:0]    data_byte,
  input  bsd_pkg::cfg_t cfg,
  output bsd_pkg::res_t res
);
  import bsd_pkg::*;

  phase_t                 phase_r, phase_nxt;
  logic [LENGTH_BITS-1:0] remaining_r, remaining_nxt;
  logic [LENGTH_BITS-1:0] length_store_r, length_store_nxt;
  logic [7:0]             version_r, version_nxt;
  logic [15:0]            block_cnt_r, block_cnt_nxt;
  logic [7:0]             type_r, type_nxt;
  logic [DC_W-1:0]        digit_cnt_r, digit_cnt_nxt;
  logic                   digits_seen_r, digits_seen_nxt;

  phase_t                 ep;
  logic [LENGTH_BITS-1:0] er;
  logic [DC_W-1:0]        dc_e;
  logic                   seen_e;
  logic [LENGTH_BITS-1:0] trail_left;
  logic [LENGTH_BITS+3:0] len_acc;
  logic [11:0]            ver_acc;
  logic                   is_dec, is_hex, is_hash;
  logic [3:0]             digit;

  assign is_dec  = (data_byte >= 8'h30) && (data_byte <= 8'h39);
  assign is_hex  = is_dec || ((data_byte >= 8'h61) && (data_byte <= 8'h66)) ||
                   ((data_byte >= 8'h41) && (data_byte <= 8'h46));
  assign is_hash = (data_byte == CH_HASH);
  assign digit   = data_byte[3:0];

  assign ver_acc = ({4'd0, version_r} << 3) + ({4'd0, version_r} << 1) + {8'd0, digit};

  always_comb begin
    ep     = phase_r;
    er     = remaining_r;
    seen_e = digits_seen_r;
    dc_e   = digit_cnt_r;

    // resolve phases that pass the byte on without taking it
    if (phase_r == PH_HDRLEN && !is_dec) begin
      ep = (remaining_r == '0) ? PH_DATALEN : PH_HEADER;
    end else if (phase_r == PH_HEADER && remaining_r == '0) begin
      ep = PH_DATALEN;
    end
    if (ep == PH_DATALEN && !is_dec) ep = PH_HDREND;
    if (phase_r == PH_CONTENT && remaining_r == '0) begin
      ep = PH_TRAILER;
      er = TRAILER_MARKS;
    end
    if (phase_r == PH_CHECKSUM) begin
      seen_e = 1'b0;
      if (data_byte != CH_LF && cfg.checksum_mode != MODE_NONE) begin
        ep   = PH_CHECKDATA;
        dc_e = DC_W'(DIGEST_HEX_DIGITS);
      end else begin
        ep = PH_BLOCKEND;
      end
    end
    if (ep == PH_CHECKDATA && !(dc_e != '0 && is_hex)) ep = PH_BLOCKEND;
  end

  assign len_acc = ({4'd0, er} << 3) + ({4'd0, er} << 1) + {{LENGTH_BITS{1'b0}}, digit};
  assign trail_left = er - LENGTH_BITS'(er != '0);

  always_comb begin
    phase_nxt        = ep;
    remaining_nxt    = er;
    length_store_nxt = length_store_r;
    version_nxt      = version_r;
    block_cnt_nxt    = block_cnt_r;
    type_nxt         = type_r;
    digit_cnt_nxt    = dc_e;
    digits_seen_nxt  = seen_e;

    res.byte_kind      = KIND_SKIP;
    res.hash_feed      = 1'b0;
    res.error_code     = ERR_NONE;
    res.content_length = '0;
    res.need_verify    = 1'b0;

    unique case (ep)
      PH_TYPE: begin
        if (is_hash) begin
          res.error_code = ERR_UNEXP_TRAIL;
        end else begin
          res.byte_kind = KIND_TYPE;
          res.hash_feed = 1'b1;
          type_nxt      = data_byte;
          block_cnt_nxt = block_cnt_r + 16'd1;
          version_nxt   = 8'd0;
          phase_nxt     = PH_VERSION;
        end
      end
      PH_VERSION: begin
        if (is_dec) begin
          if (|ver_acc[11:8]) begin
            res.error_code = ERR_VERSION;
          end else begin
            version_nxt   = ver_acc[7:0];
            res.hash_feed = 1'b1;
          end
        end else if (data_byte != CH_V) begin
          res.error_code = ERR_FORMAT;
        end else if (version_r != cfg.expected_version) begin
          res.error_code = ERR_VERSION;
        end else begin
          res.hash_feed = 1'b1;
          remaining_nxt = '0;
          phase_nxt     = PH_HDRLEN;
        end
      end
      PH_HDRLEN, PH_DATALEN: begin
        if (|len_acc[LENGTH_BITS+3:LENGTH_BITS]) begin
          res.error_code = ERR_OVERFLOW;
        end else begin
          remaining_nxt = len_acc[LENGTH_BITS-1:0];
          res.hash_feed = 1'b1;
        end
      end
      PH_HEADER, PH_CONTENT: begin
        res.byte_kind = (ep == PH_HEADER) ? KIND_HEADER : KIND_CONTENT;
        res.hash_feed = 1'b1;
        remaining_nxt = er - LENGTH_BITS'(1);
      end
      PH_HDREND: begin
        if (data_byte != CH_LF) begin
          res.error_code = ERR_HDR_LF;
        end else begin
          res.hash_feed    = 1'b1;
          length_store_nxt = er;
          phase_nxt        = PH_CONTENT;
        end
      end
      PH_TRAILER: begin
        if (!is_hash) begin
          res.error_code = ERR_NO_TRAILER;
        end else begin
          res.hash_feed = 1'b1;
          remaining_nxt = trail_left;
          if (trail_left == '0) phase_nxt = PH_CHECKSUM;
        end
      end
      PH_CHECKDATA: begin
        res.byte_kind   = KIND_DIGIT;
        digit_cnt_nxt   = dc_e - DC_W'(1);
        digits_seen_nxt = 1'b1;
      end
      PH_BLOCKEND: begin
        if (data_byte != CH_LF) begin
          res.error_code = ERR_TRAIL_LF;
        end else begin
          res.byte_kind      = KIND_DONE;
          res.content_length = CONTENT_LEN_W'(length_store_r);
          res.need_verify    = cfg.checksum_mode[1] ||
                               (cfg.checksum_mode == MODE_IF_DIGITS && seen_e);
          phase_nxt          = PH_SEARCH;
        end
      end
      default: begin
        // search, and codes outside the phase list
        phase_nxt = PH_SEARCH;
        if (is_hash) begin
          res.hash_feed = 1'b1;
          phase_nxt     = PH_TYPE;
        end
      end
    endcase

    if (res.error_code != ERR_NONE) begin
      res.byte_kind = KIND_ERROR;
      res.hash_feed = is_hash;
      phase_nxt     = is_hash ? PH_TYPE : PH_SEARCH;
    end

    res.byte_value  = data_byte;
    res.block_index = block_cnt_nxt;
    res.block_kind  = type_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_SEARCH;
      remaining_r    <= '0;
      length_store_r <= '0;
      version_r      <= 8'd0;
      block_cnt_r    <= 16'hFFFF;
      type_r         <= 8'd0;
      digit_cnt_r    <= '0;
      digits_seen_r  <= 1'b0;
    end else if (step_en) begin
      phase_r        <= phase_nxt;
      remaining_r    <= remaining_nxt;
      length_store_r <= length_store_nxt;
      version_r      <= version_nxt;
      block_cnt_r    <= block_cnt_nxt;
      type_r         <= type_nxt;
      digit_cnt_r    <= digit_cnt_nxt;
      digits_seen_r  <= digits_seen_nxt;
    end
  end

endmodule

// ===== hw/rtl/block_stream_deframer.sv =====
// Top level of the block stream deframer: input stage, decode, result register.
//
//  channel  direction  handshake           payload
//  in       sink       in_valid/in_ready   in_data_byte
//  out      source     out_valid/out_ready out_byte_kind .. out_need_verify
//  cfg      APB slave  psel/penable/pready checksum_mode, expected_version
//
// One result beat per input beat; a byte passes from acceptance to result through
// the input register, then decode into the result register.
// One byte per cycle sustained while results are taken; the decoder state updates with each step.
// Synchronous active-low reset empties both stages and resets the deframer state.
// A stalled result holds; the input stage still takes a beat while it is empty, then fills.
`timescale 1ns / 1ps
module block_stream_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_byte_kind,
  output logic [7:0]  out_byte_value,
  output logic        out_hash_feed,
  output logic [2:0]  out_error_code,
  output logic [15:0] out_block_index,
  output logic [7:0]  out_block_kind,
  output logic [23:0] out_content_length,
  output logic        out_need_verify,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bsd_pkg::*;

  cfg_t       cfg;
  res_t       res;
  res_t       res_r;
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free, step;

  bsd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bsd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step),
    .data_byte (s1_byte_r),
    .cfg       (cfg),
    .res       (res)
  );

  assign out_free = !out_valid_r || out_ready;
  assign step     = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) s1_valid_nxt = 1'b1;
    else if (step)            s1_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (step)           out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_byte_r <= in_data_byte;
    if (step)                 res_r     <= res;
  end

  assign out_valid          = out_valid_r;
  assign out_byte_kind      = res_r.byte_kind;
  assign out_byte_value     = res_r.byte_value;
  assign out_hash_feed      = res_r.hash_feed;
  assign out_error_code     = res_r.error_code;
  assign out_block_index    = res_r.block_index;
  assign out_block_kind     = res_r.block_kind;
  assign out_content_length = res_r.content_length;
  assign out_need_verify    = res_r.need_verify;

  a_err_only_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_error_code != ERR_NONE) |-> out_byte_kind == KIND_ERROR)
    else $error("error code without error kind");

  a_verify_at_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_need_verify |-> out_byte_kind == KIND_DONE)
    else $error("verify flag outside block end");

  a_digit_not_hashed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_byte_kind == KIND_DIGIT) |-> !out_hash_feed)
    else $error("checksum digit fed to digest");

  a_stage_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid && !out_ready |-> !in_ready)
    else $error("input taken while both stages full");

endmodule
